/* src/fcf_pkg.sv */
// ----------------------------------------------------------------------------
// fcf_pkg
// Shared types and constants for the correlation-form FIR filter: tap count,
// field widths, adder tree shape and input operation codes.
// ----------------------------------------------------------------------------
package fcf_pkg;

  // number of taps held in the window and the coefficient store
  localparam int TAPS = 64;

  // payload field widths
  localparam int OP_W   = 1;
  localparam int IDX_W  = 6;
  localparam int VAL_W  = 16;
  localparam int PROD_W = 2 * VAL_W;
  localparam int SUM_W  = 40;

  // samples held, 0 up to TAPS
  localparam int CNT_W = $clog2(TAPS + 1);

  // adder tree: four inputs per node, one register per tree level
  localparam int TREE_LVLS = ($clog2(TAPS) + 1) / 2;
  localparam int PAD       = 1 << (2 * TREE_LVLS);

  typedef logic signed [VAL_W-1:0]  sample_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef sample_t tap_arr_t  [TAPS];
  typedef prod_t   prod_arr_t [TAPS];

  // input operation codes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 1'b0,
    OP_PUSH = 1'b1
  } op_e;

endpackage

/* src/fcf_tap_store.sv */
// ----------------------------------------------------------------------------
// fcf_tap_store
// Sample shift line, coefficient registers and fill count. A push that fills
// or keeps the window full leaves a pending transaction for the multipliers.
// ----------------------------------------------------------------------------
module fcf_tap_store
  import fcf_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [OP_W-1:0]         op_i,
  input  logic [IDX_W-1:0]        coef_index_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    pend_valid_o,
  input  logic                    mult_ready_i,
  output tap_arr_t                window_o,
  output tap_arr_t                coef_o
);

  tap_arr_t           window_q, window_d;
  tap_arr_t           coef_q, coef_d;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic               pend_q, pend_d;
  logic               in_ready;
  logic               accept;
  logic               is_push;
  logic               will_be_full;

  // handshake: the window may only move once the pending snapshot is taken
  assign in_ready   = !pend_q || mult_ready_i;
  assign in_stall_o = !in_ready;
  assign accept     = in_valid_i && in_ready;
  assign is_push    = (op_i == OP_PUSH);

  // window is full after this push when at most one slot was empty
  assign will_be_full = (fill_q >= CNT_W'(TAPS - 1));

  // next state of window, coefficients, fill count and pending flag
  always_comb begin
    window_d = window_q;
    coef_d   = coef_q;
    fill_d   = fill_q;
    pend_d   = pend_q && !mult_ready_i;
    if (accept && is_push) begin
      for (int j = 0; j < TAPS - 1; j++) begin
        window_d[j] = window_q[j+1];
      end
      window_d[TAPS-1] = value_i;
      if (fill_q != CNT_W'(TAPS)) begin
        fill_d = fill_q + CNT_W'(1);
      end
      pend_d = will_be_full;
    end else if (accept) begin
      // loads beyond the last tap match no entry and are dropped
      for (int j = 0; j < TAPS; j++) begin
        if (32'(coef_index_i) == j) begin
          coef_d[j] = value_i;
        end
      end
    end
  end

  // control and coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < TAPS; j++) begin
        coef_q[j] <= '0;
      end
      fill_q <= '0;
      pend_q <= 1'b0;
    end else begin
      coef_q <= coef_d;
      fill_q <= fill_d;
      pend_q <= pend_d;
    end
  end

  // sample shift line, only read once full
  always_ff @(posedge clk_i) begin
    window_q <= window_d;
  end

  assign pend_valid_o = pend_q;
  assign window_o     = window_q;
  assign coef_o       = coef_q;

endmodule

/* src/fcf_mult_bank.sv */
// ----------------------------------------------------------------------------
// fcf_mult_bank
// One 16x16 signed multiplier per tap with a registered product stage.
// ----------------------------------------------------------------------------
module fcf_mult_bank
  import fcf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      pend_valid_i,
  output logic      mult_ready_o,
  input  tap_arr_t  window_i,
  input  tap_arr_t  coef_i,
  output logic      prod_valid_o,
  input  logic      tree_ready_i,
  output prod_arr_t prod_o
);

  prod_arr_t prod_q;
  logic      vld_q;

  assign mult_ready_o = !vld_q || tree_ready_i;

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (mult_ready_o) begin
      vld_q <= pend_valid_i;
    end
  end

  // products, taken from the window and coefficients as they stand
  always_ff @(posedge clk_i) begin
    if (mult_ready_o) begin
      for (int j = 0; j < TAPS; j++) begin
        prod_q[j] <= window_i[j] * coef_i[j];
      end
    end
  end

  assign prod_valid_o = vld_q;
  assign prod_o       = prod_q;

endmodule

/* src/fcf_adder_tree.sv */
// ----------------------------------------------------------------------------
// fcf_adder_tree
// Registered four-input adder tree over the products; the last level is the
// result register.
// ----------------------------------------------------------------------------
module fcf_adder_tree
  import fcf_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    prod_valid_i,
  output logic                    tree_ready_o,
  input  prod_arr_t               prod_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [SUM_W-1:0] sum_o
);

  sum_t                 leaf [PAD];
  sum_t                 node_q [TREE_LVLS][PAD];
  sum_t                 node_d [TREE_LVLS][PAD];
  logic [TREE_LVLS-1:0] vld_q;
  logic [TREE_LVLS:0]   rdy;

  // leaves: sign-extended products, zero past the last tap
  always_comb begin
    for (int i = 0; i < PAD; i++) begin
      leaf[i] = '0;
    end
    for (int i = 0; i < TAPS; i++) begin
      leaf[i] = SUM_W'(prod_i[i]);
    end
  end

  // ready chain, from the result register back to the products
  always_comb begin
    rdy[TREE_LVLS] = !out_stall_i;
    for (int k = TREE_LVLS - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  // each level adds groups of four from the level below
  always_comb begin
    for (int k = 0; k < TREE_LVLS; k++) begin
      for (int i = 0; i < PAD; i++) begin
        node_d[k][i] = '0;
      end
    end
    for (int i = 0; i < (PAD >> 2); i++) begin
      for (int m = 0; m < 4; m++) begin
        node_d[0][i] = node_d[0][i] + leaf[4*i+m];
      end
    end
    for (int k = 1; k < TREE_LVLS; k++) begin
      for (int i = 0; i < (PAD >> (2 * (k + 1))); i++) begin
        for (int m = 0; m < 4; m++) begin
          node_d[k][i] = node_d[k][i] + node_q[k-1][4*i+m];
        end
      end
    end
  end

  // level valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= prod_valid_i;
      end
      for (int k = 1; k < TREE_LVLS; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // level sums
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < TREE_LVLS; k++) begin
      if (rdy[k]) begin
        node_q[k] <= node_d[k];
      end
    end
  end

  assign tree_ready_o = rdy[0];
  assign out_valid_o  = vld_q[TREE_LVLS-1];
  assign sum_o        = node_q[TREE_LVLS-1][0];

endmodule

/* src/fir_correlation_filter_core.sv */
// ----------------------------------------------------------------------------
// fir_correlation_filter_core
// Streaming FIR filter in correlation form with loadable coefficients.
//
//   channel  signals                             direction
//   in       in_valid_i, in_stall_o,             into the block
//            op_i, coef_index_i, value_i
//   out      out_valid_o, out_stall_i, sum_o     out of the block
//
// One transaction per clock while in_stall_o is low: a push or a coefficient load each cycle.
// A push with a full window gives its sum after it has passed the window
// register, the product register and one register per four-input adder
// tree level.
// Reset clears the coefficients and the fill count; no sum appears until
// TAPS samples have been pushed.
// out_stall_i holds the pipeline stage by stage; in_stall_o rises only
// when every stage holds a transaction.
// ----------------------------------------------------------------------------
module fir_correlation_filter_core
  import fcf_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [OP_W-1:0]         op_i,
  input  logic [IDX_W-1:0]        coef_index_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [SUM_W-1:0] sum_o
);

  tap_arr_t  window;
  tap_arr_t  coef;
  prod_arr_t prod;
  logic      pend_valid;
  logic      mult_ready;
  logic      prod_valid;
  logic      tree_ready;

  // window, coefficients and fill count
  fcf_tap_store u_tap_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .coef_index_i (coef_index_i),
    .value_i      (value_i),
    .pend_valid_o (pend_valid),
    .mult_ready_i (mult_ready),
    .window_o     (window),
    .coef_o       (coef)
  );

  // per-tap products
  fcf_mult_bank u_mult_bank (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pend_valid_i (pend_valid),
    .mult_ready_o (mult_ready),
    .window_i     (window),
    .coef_i       (coef),
    .prod_valid_o (prod_valid),
    .tree_ready_i (tree_ready),
    .prod_o       (prod)
  );

  // reduction and result register
  fcf_adder_tree u_adder_tree (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .prod_valid_i (prod_valid),
    .tree_ready_o (tree_ready),
    .prod_i       (prod),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sum_o        (sum_o)
  );

`ifndef NO_ASSERTIONS
  // input backs up only when the result register is full and stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && pend_valid && prod_valid))
    else $error("input stalled with room in the pipeline");

  // a coefficient load never leaves a pending sum behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (op_i == OP_LOAD)) |=> !pend_valid)
    else $error("coefficient load produced a pending sum");

  // a pending snapshot is consumed or held, never dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_valid && !mult_ready) |=> pend_valid)
    else $error("pending sum lost while multipliers were busy");
`endif

endmodule

/* tb/fir_correlation_filter_core_test.sv */
// ----------------------------------------------------------------------------
// fir_correlation_filter_core_test
// Self-checking bench for the correlation-form FIR filter core. Coefficient
// loads and sample pushes are driven in random bursts with gaps. The output
// side stalls on a changing pattern, and once for a long stretch so that the
// pipeline fills up. A scoreboard mirrors the sample window and coefficient
// store and checks every sum in order.
// ----------------------------------------------------------------------------
module fir_correlation_filter_core_test;
  import fcf_pkg::*;

  // mirror of the filter state, queue of sums still to come out
  class tap_sum_tracker;
    sample_t window [TAPS];
    sample_t coefs  [TAPS];
    int      fill;
    sum_t    expected_sums [$];

    function new();
      for (int j = 0; j < TAPS; j++) begin
        window[j] = '0;
        coefs[j]  = '0;
      end
      fill = 0;
    endfunction

    // exact dot product of window and coefficients, cut to the sum width
    function sum_t window_sum();
      longint acc;
      acc = 0;
      for (int j = 0; j < TAPS; j++) begin
        acc += longint'(window[j]) * longint'(coefs[j]);
      end
      return sum_t'(acc);
    endfunction

    // update the mirror for one accepted input transaction
    function void note_item(op_e op, logic [IDX_W-1:0] idx, sample_t value);
      if (op == OP_LOAD) begin
        // loads beyond the taps are dropped
        if (int'(idx) < TAPS) coefs[idx] = value;
      end else begin
        for (int j = 0; j < TAPS - 1; j++) begin
          window[j] = window[j+1];
        end
        window[TAPS-1] = value;
        if (fill < TAPS) fill++;
        // no sum until the window is full
        if (fill == TAPS) expected_sums.push_back(window_sum());
      end
    endfunction

    // compare one output transaction with the oldest expected sum
    function bit check_sum(sum_t got, output string msg);
      sum_t want;
      msg = "";
      if (expected_sums.size() == 0) begin
        msg = $sformatf("sum %0d with nothing expected", got);
        return 1'b0;
      end
      want = expected_sums.pop_front();
      if (got !== want) begin
        msg = $sformatf("sum %0d, expected %0d", got, want);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function int pending();
      return expected_sums.size();
    endfunction
  endclass

  localparam int NUM_ITEMS = 1650;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [OP_W-1:0]         op_i;
  logic [IDX_W-1:0]        coef_index_i;
  logic signed [VAL_W-1:0] value_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [SUM_W-1:0] sum_o;

  tap_sum_tracker sums;
  int    mismatches = 0;
  int    items_accepted = 0;
  int    burst_left = 0;
  bit    hold_done = 1'b0;
  string check_msg;

  fir_correlation_filter_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .coef_index_i (coef_index_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sum_o        (sum_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // random value, leaning on the extremes
  function automatic sample_t rand_value();
    case ($urandom_range(0, 7))
      0: return sample_t'(16'h8000);
      1: return sample_t'(16'h7fff);
      2: return sample_t'(16'h0000);
      3: return sample_t'(16'hffff);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // offer one transaction, with a random gap at the start of each burst
  task automatic send_item(input op_e op, input logic [IDX_W-1:0] idx,
                           input sample_t value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 120)
                                               : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i   <= 1'b0;
        op_i         <= OP_W'($urandom_range(0, 1));
        coef_index_i <= IDX_W'($urandom);
        value_i      <= VAL_W'($urandom);
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    op_i         <= op;
    coef_index_i <= idx;
    value_i      <= value;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sums.note_item(op, idx, value);
    items_accepted++;
  endtask

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (!sums.check_sum(sum_o, check_msg)) report_mismatch(check_msg);
    end
  end

  // receiver stall pattern, with one long hold-off
  initial begin : receiver
    int mode;
    int span;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!hold_done && items_accepted > 300) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      for (int k = 0; k < span; k++) begin
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= 1'($urandom_range(0, 1));
          2: out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= (k % 4 == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // run limit
  initial begin
    #4000000;
    $display("fir_correlation_filter_core_test: errors");
    $finish;
  end

  // stimulus and end of run
  initial begin : main
    int      kind;
    int      n;
    int      wait_cycles;
    sample_t v;
    sums = new();
    in_valid_i   <= 1'b0;
    op_i         <= OP_LOAD;
    coef_index_i <= '0;
    value_i      <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extreme and patterned coefficients at the edge and middle indexes
    send_item(OP_LOAD, IDX_W'(0), sample_t'(16'h8000));
    send_item(OP_LOAD, IDX_W'(TAPS - 1), sample_t'(16'h7fff));
    send_item(OP_LOAD, IDX_W'(1), sample_t'(16'h7fff));
    send_item(OP_LOAD, IDX_W'(TAPS - 2), sample_t'(16'h8000));
    send_item(OP_LOAD, IDX_W'(31), sample_t'(16'hffff));
    send_item(OP_LOAD, IDX_W'(32), sample_t'(16'h0001));
    send_item(OP_LOAD, IDX_W'(7), sample_t'(16'h5555));
    send_item(OP_LOAD, IDX_W'(8), sample_t'(16'haaaa));
    // directed: pushes while the window is still filling
    send_item(OP_PUSH, IDX_W'(0), sample_t'(16'h7fff));
    send_item(OP_PUSH, IDX_W'(63), sample_t'(16'h8000));
    send_item(OP_PUSH, IDX_W'(0), sample_t'(16'h0000));
    send_item(OP_PUSH, IDX_W'(21), sample_t'(16'hffff));
    send_item(OP_PUSH, IDX_W'(42), sample_t'(16'h0001));
    send_item(OP_PUSH, IDX_W'(0), sample_t'(16'h5555));
    send_item(OP_PUSH, IDX_W'(0), sample_t'(16'haaaa));

    // random sequences
    while (items_accepted < NUM_ITEMS) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1: begin
          // scattered coefficient loads
          n = $urandom_range(1, 16);
          repeat (n) send_item(OP_LOAD, IDX_W'($urandom), rand_value());
        end
        7: begin
          // all taps at one extreme, samples mostly at the same extreme, the odd one at the other
          v = $urandom_range(0, 1) ? sample_t'(16'h8000) : sample_t'(16'h7fff);
          for (int k = 0; k < TAPS; k++) send_item(OP_LOAD, IDX_W'(k), v);
          for (int k = 0; k < TAPS; k++) begin
            send_item(OP_PUSH, IDX_W'($urandom),
                      ($urandom_range(0, 7) == 0) ? ~v : v);
          end
        end
        8: begin
          // noise: any op, any field
          n = $urandom_range(1, 8);
          repeat (n) begin
            send_item($urandom_range(0, 1) ? OP_PUSH : OP_LOAD,
                      IDX_W'($urandom), sample_t'($urandom));
          end
        end
        9: begin
          // full coefficient reload
          for (int k = 0; k < TAPS; k++) send_item(OP_LOAD, IDX_W'(k), rand_value());
        end
        default: begin
          // sample run with the odd load while streaming
          n = $urandom_range(1, 90);
          repeat (n) begin
            if ($urandom_range(0, 11) == 0) begin
              send_item(OP_LOAD, IDX_W'($urandom), rand_value());
            end else begin
              send_item(OP_PUSH, IDX_W'($urandom), rand_value());
            end
          end
        end
      endcase
    end
    in_valid_i <= 1'b0;

    // drain
    wait_cycles = 0;
    while (sums.pending() != 0 && wait_cycles < 5000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (20) @(posedge clk_i);
    if (sums.pending() != 0) begin
      report_mismatch($sformatf("%0d sums never came out", sums.pending()));
    end
    if (mismatches == 0) begin
      $display("fir_correlation_filter_core_test: clean");
    end else begin
      $display("fir_correlation_filter_core_test: errors");
    end
    $finish;
  end

endmodule
